// ----- rtl/sch_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sch_pkg
// Command codes, register map and result layout for the serial command handler.
// ---------------------------------------------------------------------------
package sch_pkg;

    localparam logic [7:0]  CMD_ON       = 8'hA0;
    localparam logic [7:0]  CMD_OFF      = 8'hA1;
    localparam logic [7:0]  CMD_REF      = 8'hA2;
    localparam logic [7:0]  CMD_MEAS     = 8'hA3;

    localparam logic [15:0] PERIOD_RESET = 16'd9614;

    // register index (byte address bit 2)
    localparam logic        REG_PWM_PERIOD = 1'b0;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 64;

    typedef struct packed {
        logic [15:0] period_value;
        logic        period_load;
        logic        pwm_enable;
        logic [15:0] ref_value;
        logic        ref_valid;
        logic [15:0] coef_value;
        logic [2:0]  coef_index;
        logic        coef_valid;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/serial_command_handler_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// serial_command_handler_unit
// Decodes received serial bytes into echoes, coefficient and reference writes,
// PWM enable/period control and measurement replies.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake                 Content
// s_axis    in   s_axis_tvalid/tready      rx byte + measured output sample
// m_axis    out  m_axis_tvalid/tready      one result per input transfer
// apb       in   psel/penable/pready       pwm_period register at 0x0
//
// Each transfer passes an input register and a result register, with the
// single decode step between them: one transfer per cycle sustained while
// m_axis_tready stays high. A full input register holds while the result
// register waits on m_axis_tready. Reset clears the command state, the PWM
// enable and both valid flags, and loads pwm_period with 9614.
// ---------------------------------------------------------------------------
module serial_command_handler_unit #(
    parameter int unsigned NUM_COEFS = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // rx_byte [7:0], measured_output [23:8]
    input  wire logic [sch_pkg::IN_W-1:0] s_axis_tdata,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // tx_valid [0], tx_byte [8:1], coef_valid [9], coef_index [12:10],
    // coef_value [28:13], ref_valid [29], ref_value [45:30], pwm_enable [46],
    // period_load [47], period_value [63:48]
    output logic [sch_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sch_pkg::*;

    localparam int unsigned LAST_STEP = 2 * NUM_COEFS + 1;
    localparam int unsigned STEP_W    = $clog2(LAST_STEP + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ON,
        ST_REF,
        ST_MEAS
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [7:0]          low_hold_reg, low_hold_next;
    logic [2:0]          coef_cnt_reg, coef_cnt_next;
    logic [7:0]          reply_hold_reg, reply_hold_next;
    logic                pwm_on_reg, pwm_on_next;
    logic [15:0]         period_reg;

    logic                in_valid_reg;
    logic [IN_W-1:0]     in_data_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res_next;
    logic                advance;

    logic [7:0]          rx;
    logic [15:0]         meas;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PWM_PERIOD) ? {16'd0, period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_PWM_PERIOD))
        begin
            period_reg <= pwdata[15:0];
        end
    end

    // ---------------- handshake ----------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign rx   = in_data_reg[7:0];
    assign meas = in_data_reg[23:8];

    // ---------------- decode ----------------
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        low_hold_next   = low_hold_reg;
        coef_cnt_next   = coef_cnt_reg;
        reply_hold_next = reply_hold_reg;
        pwm_on_next     = pwm_on_reg;
        res_next        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                case (rx)
                    CMD_ON:
                    begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = CMD_ON;
                        step_next         = STEP_W'(1);
                        coef_cnt_next     = 3'd0;
                        state_next        = ST_ON;
                    end
                    CMD_OFF:
                    begin
                        pwm_on_next = 1'b0;
                    end
                    CMD_REF:
                    begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = CMD_REF;
                        step_next         = STEP_W'(1);
                        state_next        = ST_REF;
                    end
                    CMD_MEAS:
                    begin
                        // high reply is measured>>>10, both replies gated by PWM
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = pwm_on_reg ?
                                            {meas[15], meas[15], meas[15:10]} : 8'd0;
                        reply_hold_next   = pwm_on_reg ? meas[9:2] : 8'd0;
                        state_next        = ST_MEAS;
                    end
                    default:
                    begin
                        // drop unknown bytes, stay idle
                    end
                endcase
            end
            ST_ON:
            begin
                if (step_reg < STEP_W'(LAST_STEP))
                begin
                    if (step_reg[0])
                    begin
                        low_hold_next = rx;
                    end
                    else
                    begin
                        res_next.coef_valid = 1'b1;
                        res_next.coef_index = coef_cnt_reg;
                        res_next.coef_value = {rx, low_hold_reg};
                        coef_cnt_next       = coef_cnt_reg + 3'd1;
                    end
                    step_next         = step_reg + STEP_W'(1);
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = CMD_ON;
                end
                else
                begin
                    // period byte: consume it, load period from pwm_period, enable PWM
                    res_next.period_load  = 1'b1;
                    res_next.period_value = period_reg;
                    pwm_on_next           = 1'b1;
                    step_next             = '0;
                    coef_cnt_next         = 3'd0;
                    state_next            = ST_IDLE;
                end
            end
            ST_REF:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    low_hold_next     = rx;
                    step_next         = STEP_W'(2);
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = CMD_REF;
                end
                else
                begin
                    res_next.ref_valid = 1'b1;
                    res_next.ref_value = {rx, low_hold_reg};
                    step_next          = '0;
                    state_next         = ST_IDLE;
                end
            end
            ST_MEAS:
            begin
                res_next.tx_valid = 1'b1;
                res_next.tx_byte  = reply_hold_reg;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.pwm_enable = pwm_on_next;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            low_hold_reg   <= 8'd0;
            coef_cnt_reg   <= 3'd0;
            reply_hold_reg <= 8'd0;
            pwm_on_reg     <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                state_reg      <= state_next;
                step_reg       <= step_next;
                low_hold_reg   <= low_hold_next;
                coef_cnt_reg   <= coef_cnt_next;
                reply_hold_reg <= reply_hold_next;
                pwm_on_reg     <= pwm_on_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

endmodule
`default_nettype wire
